// ===== design/remote_range_allocator_macros.svh =====
// Assertion macros for the remote range allocator.
`ifndef REMOTE_RANGE_ALLOCATOR_MACROS_SVH
`define REMOTE_RANGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rra_pkg.sv =====
// Shared types and codes of the remote range allocator.
package rra_pkg;

	localparam int LOC_W   = 48;
	localparam int REM_W   = 41;
	localparam int LEN_W   = 40;
	localparam int GRP_W   = 16;
	localparam int SIZE_W  = 21;
	localparam int MIB_SHIFT = 20;

	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_FREE_GRP = 2'd2;
	localparam logic [1:0] OP_FREE_ALL = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISALIGN = 2'd1;
	localparam logic [1:0] ST_NOSPACE  = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// The local start carries one extra bit: an upper piece may start at a
	// hole end that lies past the top of the 48-bit input range.
	typedef struct packed {
		logic [LOC_W:0]   loc;
		logic [REM_W-1:0] rem;
		logic [LEN_W-1:0] len;
		logic [GRP_W-1:0] grp;
	} map_ent_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load;
		logic       prime;
		logic       scan;
		logic       copy;
		logic       commit;
		logic       clear;
		logic       fin;
		logic [1:0] st;
		logic       use_at;
	} rra_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] op;
		logic       misalign;
		logic       zero_len;
		logic       tbl_full;
		logic       scan_hit;
		logic       scan_last_ok;
		logic       scan_last_fail;
		logic       copy_done;
		logic       copy_fail;
	} rra_stat_t;

endpackage

// ===== design/rra_datapath.sv =====
// Datapath of the remote range allocator: mapping memory, scan and copy logic.
module rra_datapath #(
	parameter int MAX_MAPS   = 64,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rra_pkg::rra_cmd_t                     cmd,
	output rra_pkg::rra_stat_t                    stat,
	input  logic                                  cfg_wr_en,
	input  logic [rra_pkg::SIZE_W-1:0]            cfg_wr_data,
	input  logic [1:0]                            op,
	input  logic [rra_pkg::GRP_W-1:0]             group_id,
	input  logic [rra_pkg::LOC_W-1:0]             local_addr,
	input  logic [rra_pkg::LEN_W-1:0]             length,
	output logic [1:0]                            status,
	output logic [rra_pkg::REM_W-1:0]             remote_addr,
	output logic [$clog2(MAX_MAPS+1)-1:0]         entries_used
);
	import rra_pkg::*;

	localparam int CW    = $clog2(MAX_MAPS + 1);
	localparam int AW    = $clog2(MAX_MAPS);
	localparam int PB    = $clog2(PAGE_BYTES);
	localparam int DEPTH = 2 * (2 ** AW);

	map_ent_t mem [DEPTH];

	logic [1:0]         op_q;
	logic [GRP_W-1:0]   grp_q;
	logic [LOC_W-1:0]   loc_q;
	logic [LEN_W-1:0]   len_q;
	logic [LOC_W:0]     hi_q;
	logic [SIZE_W-1:0]  size_q;
	logic               bank_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      r_q;
	map_ent_t           rdata_q;
	logic               split_q;
	logic               ins_q;
	logic [REM_W:0]     cand_q;
	logic [REM_W-1:0]   at_q;
	logic [1:0]         status_q;
	logic [REM_W-1:0]   raddr_q;
	logic [CW-1:0]      used_q;

	logic               end_in;
	logic [REM_W+1:0]   sum;
	logic [REM_W-1:0]   space;
	logic               hit;
	logic               last_ok;

	logic               emit;
	map_ent_t           e_ent;
	logic               c_adv;
	logic               c_done;
	logic               split_set;
	logic               split_clr;
	logic               ins_set;
	logic               adv;
	logic               we;
	logic [LOC_W:0]     s_ext;
	logic [LOC_W:0]     e_ext;
	logic [LOC_W:0]     lo_ext;
	logic               has_lo;
	logic               has_hi;

	assign end_in  = (r_q == count_q);
	assign sum     = {1'b0, cand_q} + (REM_W+2)'(len_q);
	assign space   = REM_W'(size_q) << MIB_SHIFT;
	assign hit     = !end_in && (sum <= (REM_W+2)'(rdata_q.rem));
	assign last_ok = end_in && (sum < (REM_W+2)'(space));

	assign s_ext  = rdata_q.loc;
	assign e_ext  = s_ext + (LOC_W+1)'(rdata_q.len);
	assign lo_ext = {1'b0, loc_q};
	assign has_lo = lo_ext > s_ext;
	assign has_hi = hi_q < e_ext;

	always_comb begin
		emit      = 1'b0;
		e_ent     = rdata_q;
		c_adv     = 1'b0;
		c_done    = 1'b0;
		split_set = 1'b0;
		split_clr = 1'b0;
		ins_set   = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (!ins_q && (end_in || rdata_q.rem > at_q)) begin
				emit    = 1'b1;
				e_ent   = '{loc: {1'b0, loc_q}, rem: at_q, len: len_q, grp: grp_q};
				ins_set = 1'b1;
			end else if (end_in) begin
				c_done = 1'b1;
			end else begin
				emit  = 1'b1;
				c_adv = 1'b1;
			end
		end else if (end_in) begin
			c_done = 1'b1;
		end else if (rdata_q.grp != grp_q) begin
			emit  = 1'b1;
			c_adv = 1'b1;
		end else if (op_q == OP_FREE_GRP) begin
			c_adv = 1'b1;
		end else if (lo_ext >= e_ext || hi_q <= s_ext) begin
			emit  = 1'b1;
			c_adv = 1'b1;
		end else if (!split_q && has_lo) begin
			// lower piece keeps its start
			emit      = 1'b1;
			e_ent.len = LEN_W'(lo_ext - s_ext);
			if (has_hi) begin
				split_set = 1'b1;
			end else begin
				c_adv = 1'b1;
			end
		end else if (has_hi) begin
			// upper piece starts at the hole end, remote shifted alike
			emit      = 1'b1;
			e_ent.loc = hi_q;
			e_ent.rem = rdata_q.rem + REM_W'(hi_q - s_ext);
			e_ent.len = LEN_W'(e_ext - hi_q);
			split_clr = 1'b1;
			c_adv     = 1'b1;
		end else begin
			c_adv = 1'b1;
		end
	end

	assign adv = (cmd.scan && !end_in && !hit) || (cmd.copy && c_adv);
	assign we  = cmd.copy && emit && (e_ent.len != '0) && (n_q != CW'(MAX_MAPS));

	assign stat.op             = op_q;
	assign stat.misalign       = (loc_q[PB-1:0] != '0) || (len_q[PB-1:0] != '0);
	assign stat.zero_len       = (len_q == '0);
	assign stat.tbl_full       = (count_q >= CW'(MAX_MAPS));
	assign stat.scan_hit       = hit;
	assign stat.scan_last_ok   = last_ok;
	assign stat.scan_last_fail = end_in && !last_ok;
	assign stat.copy_done      = c_done;
	assign stat.copy_fail      = emit && (e_ent.len != '0) && (n_q == CW'(MAX_MAPS));

	// Mapping memory: two banks, read the live one, rebuild into the other.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[{~bank_q, n_q[AW-1:0]}] <= e_ent;
		end
		if (cmd.prime) begin
			rdata_q <= mem[{bank_q, {AW{1'b0}}}];
		end else if (adv) begin
			rdata_q <= mem[{bank_q, AW'(r_q + CW'(1))}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			grp_q <= group_id;
			loc_q <= local_addr;
			len_q <= length;
			hi_q  <= {1'b0, local_addr} + (LOC_W+1)'(length);
		end
		if (cmd.scan && (hit || last_ok)) begin
			at_q <= cand_q[REM_W-1:0];
		end
		if (cmd.prime) begin
			cand_q <= (REM_W+1)'(PAGE_BYTES);
		end else if (cmd.scan && !end_in && !hit) begin
			cand_q <= (REM_W+1)'(rdata_q.rem) + (REM_W+1)'(rdata_q.len);
		end
		if (cmd.fin) begin
			status_q <= cmd.st;
			raddr_q  <= cmd.use_at ? at_q : '0;
			used_q   <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(8192);
			bank_q  <= 1'b0;
			count_q <= '0;
			n_q     <= '0;
			r_q     <= '0;
			split_q <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (cmd.prime) begin
				r_q     <= '0;
				n_q     <= '0;
				split_q <= 1'b0;
				ins_q   <= 1'b0;
			end else begin
				if (adv) begin
					r_q <= r_q + CW'(1);
				end
				if (we) begin
					n_q <= n_q + CW'(1);
				end
				if (cmd.copy && split_set) begin
					split_q <= 1'b1;
				end else if (cmd.copy && split_clr) begin
					split_q <= 1'b0;
				end
				if (cmd.copy && ins_set) begin
					ins_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				bank_q  <= ~bank_q;
				count_q <= n_q;
			end else if (cmd.clear) begin
				count_q <= '0;
			end
		end
	end

	assign status       = status_q;
	assign remote_addr  = raddr_q;
	assign entries_used = used_q;

endmodule

// ===== design/rra_ctrl.sv =====
// Controller of the remote range allocator: operation sequencing and handshakes.
module rra_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  rra_pkg::rra_stat_t  stat,
	output rra_pkg::rra_cmd_t   cmd
);
	import rra_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_PRIME   = 3'd2;
	localparam logic [2:0] S_SCAN    = 3'd3;
	localparam logic [2:0] S_PRIME_C = 3'd4;
	localparam logic [2:0] S_COPY    = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic       use_at_q;
	logic       use_at_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		use_at_d = use_at_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				st_d     = ST_OK;
				use_at_d = 1'b0;
				state_d  = S_PRIME;
				case (stat.op)
					OP_ALLOC: begin
						if (stat.misalign) begin
							st_d    = ST_MISALIGN;
							state_d = S_FIN;
						end else if (stat.zero_len) begin
							state_d = S_FIN;
						end else if (stat.tbl_full) begin
							st_d    = ST_FULL;
							state_d = S_FIN;
						end
					end
					OP_FREE: begin
						if (stat.misalign) begin
							st_d    = ST_MISALIGN;
							state_d = S_FIN;
						end else if (stat.zero_len) begin
							state_d = S_FIN;
						end
					end
					OP_FREE_ALL: begin
						cmd.clear = 1'b1;
						state_d   = S_FIN;
					end
					default: begin
					end
				endcase
			end
			S_PRIME: begin
				cmd.prime = 1'b1;
				state_d   = (stat.op == OP_ALLOC) ? S_SCAN : S_COPY;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit || stat.scan_last_ok) begin
					state_d = S_PRIME_C;
				end else if (stat.scan_last_fail) begin
					st_d    = ST_NOSPACE;
					state_d = S_FIN;
				end
			end
			S_PRIME_C: begin
				cmd.prime = 1'b1;
				state_d   = S_COPY;
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (stat.copy_fail) begin
					st_d    = ST_FULL;
					state_d = S_FIN;
				end else if (stat.copy_done) begin
					cmd.commit = 1'b1;
					use_at_d   = (stat.op == OP_ALLOC);
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.fin    = 1'b1;
					cmd.st     = st_q;
					cmd.use_at = use_at_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			use_at_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			st_q     <= st_d;
			use_at_q <= use_at_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/remote_range_allocator.sv =====
// Top level of the remote range allocator: controller, datapath and checks.
`include "remote_range_allocator_macros.svh"

// Remote range allocator. Keeps up to MAX_MAPS mappings (local address, remote
// address, length, group) sorted by remote address in a two-bank memory of
// 2*2^clog2(MAX_MAPS) entries, one read and one write port. Operations run one
// at a time: each transaction is taken, checked, and then walks the live bank
// one entry a cycle, holding an entry while the new entry goes in ahead of it
// or a freed hole splits it, and rebuilds the table into the other bank, which
// becomes live on success. Allocate makes a first-fit scan pass, then a copy
// pass that inserts the new entry; free range and free group make one copy
// pass; free all and requests rejected by the checks make none. A result waits
// in an output register while the next transaction is already being taken. The
// user must write the space register through cfg_wr_en/cfg_wr_data only while
// no transaction is in flight; the block itself does not enforce this.
module remote_range_allocator #(
	parameter int MAX_MAPS   = 64,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rra_pkg::SIZE_W-1:0]        cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [rra_pkg::GRP_W-1:0]         group_id,
	input  logic [rra_pkg::LOC_W-1:0]         local_addr,
	input  logic [rra_pkg::LEN_W-1:0]         length,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [rra_pkg::REM_W-1:0]         remote_addr,
	output logic [$clog2(MAX_MAPS+1)-1:0]     entries_used
);
	import rra_pkg::*;

	localparam int CW = $clog2(MAX_MAPS + 1);

	rra_cmd_t  cmd;
	rra_stat_t stat;

	// Sequence each transaction: check, scan, copy, hand off the result.
	rra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold the table, the space register and the result payload.
	rra_datapath #(
		.MAX_MAPS   (MAX_MAPS),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.op           (op),
		.group_id     (group_id),
		.local_addr   (local_addr),
		.length       (length),
		.status       (status),
		.remote_addr  (remote_addr),
		.entries_used (entries_used)
	);

	// A table never holds more than its capacity.
	`RRA_ASSERT_IMP(a_used_max, out_valid, entries_used <= CW'(MAX_MAPS), "entries_used over capacity")
	// Only a successful allocate reports a remote address.
	`RRA_ASSERT_IMP(a_addr_ok, out_valid && (status != ST_OK), remote_addr == '0, "address on error")
	// Allocation never starts below the first page.
	`RRA_ASSERT_IMP(a_addr_page, out_valid && (remote_addr != '0), remote_addr >= REM_W'(PAGE_BYTES), "address below first page")
	// A taken transaction blocks input on the next cycle.
	`RRA_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall, "input not held after accept")

endmodule
